[design/adsw_pkg.sv]
// Shared types and constants for the stale-worker Adadelta update block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package adsw_pkg;
  localparam int PARAM_COUNT_DEF = 1024;
  localparam int NUM_WORKERS_DEF = 4;
  localparam int MEAN_W = 48;
  localparam int WGT_W = 17;
  localparam int MUL_W = MEAN_W + WGT_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [15:0] DECAY_RESET = 16'd62259;
  localparam logic [31:0] EPS_RESET = 32'd4295;
  localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;
  localparam logic [WGT_W-1:0] WGT_RESET = 17'd3277;
  localparam logic [WGT_W-1:0] SHRINK_Q16 = 17'd52429;
  localparam logic [MEAN_W-1:0] MEAN_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [40:0] STEP_MAX = 41'h100_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY = 1'b0,
    REG_EPS   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RD_SQRT = 2'b01,
    RD_DIV  = 2'b10
  } rd_op_t;

  typedef struct packed {
    logic   start;
    rd_op_t op;
  } rd_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } rd_rsp_t;

  typedef struct packed {
    logic signed [31:0] grad_value;
    logic signed [31:0] param_in;
    logic [2:0]         worker_rank;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] param_out;
    logic               bad_rank;
    logic               last_out;
  } out_item_t;
endpackage
`default_nettype wire

[design/adsw_mul.sv]
// Shared registered multiplier, 48 by 17 bits unsigned.
// Depends on adsw_pkg.
`default_nettype none
module adsw_mul import adsw_pkg::*; (
  input  logic              clk,
  input  logic [MEAN_W-1:0] mul_a,
  input  logic [WGT_W-1:0]  mul_b,
  output logic [MUL_W-1:0]  prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= MUL_W'(mul_a) * MUL_W'(mul_b);
  end
endmodule
`default_nettype wire

[design/adsw_rootdiv.sv]
// Iterative square root (one bit per cycle) and restoring divider sharing one subtractor.
// Depends on adsw_pkg.
`default_nettype none
module adsw_rootdiv import adsw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rd_req_t     req,
  input  logic [63:0] opa,
  input  logic [31:0] opb,
  output rd_rsp_t     rsp
);
  logic [32:0] rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] root_r, root_nxt;
  logic [31:0] div_r, div_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  rd_op_t      op_r, op_nxt;
  logic [35:0] tx, ty, diff;
  logic        ge;

  always_comb begin
    if (op_r == RD_SQRT) begin
      tx = {1'b0, rem_r, acc_r[63:62]};
      ty = {2'b00, root_r, 2'b01};
    end else begin
      tx = {2'b00, rem_r, acc_r[63]};
      ty = {4'b0000, div_r};
    end
    diff = tx - ty;
    ge = !diff[35];
  end

  always_comb begin
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    root_nxt = root_r;
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt = op_r;
    if (req.start) begin
      op_nxt = req.op;
      acc_nxt = opa;
      div_nxt = opb;
      rem_nxt = '0;
      root_nxt = '0;
      busy_nxt = 1'b1;
      cnt_nxt = (req.op == RD_SQRT) ? 7'd32 : 7'd64;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[32:0] : tx[32:0];
      if (op_r == RD_SQRT) begin
        root_nxt = {root_r[30:0], ge};
        acc_nxt = {acc_r[61:0], 2'b00};
      end else begin
        acc_nxt = {acc_r[62:0], ge};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
      op_r <= RD_SQRT;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
      op_r <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    root_r <= root_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.result = (op_r == RD_SQRT) ? {32'd0, root_r} : acc_r;
endmodule
`default_nettype wire

[design/adadelta_stale_worker_update_top.sv]
// Adadelta update with stale per-worker means: sequencer, mean memories, weights, config.
// Depends on adsw_pkg, adsw_mul and adsw_rootdiv.
// Each valid item runs two roots, a divide and the folds; the step squaring is skipped when the
// squared step would saturate, and a weight decay pass runs first at vector start. An invalid
// rank goes straight to its result (after any vector-start decay). The block takes one item at a time.
// Reset: synchronous; then a clearing pass over all PARAM_COUNT entries with in_stall high.
`default_nettype none
module adadelta_stale_worker_update_top import adsw_pkg::*; #(
  parameter int PARAM_COUNT = PARAM_COUNT_DEF,
  parameter int NUM_WORKERS = NUM_WORKERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);
  localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int KW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int ROW_W = NUM_WORKERS * MEAN_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(PARAM_COUNT - 1);
  localparam logic [KW-1:0] LAST_K = KW'(NUM_WORKERS - 1);
  localparam logic [2:0] RANK_MAX = 3'(NUM_WORKERS);

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_DECAY  = 16'h0004,
    S_RD     = 16'h0008,
    S_LD     = 16'h0010,
    S_GSQ    = 16'h0020,
    S_FOLD_G = 16'h0040,
    S_FOLD_W = 16'h0080,
    S_ROOT_N = 16'h0100,
    S_ROOT_D = 16'h0200,
    S_NUM    = 16'h0400,
    S_DIV    = 16'h0800,
    S_STEP   = 16'h1000,
    S_SSQ    = 16'h2000,
    S_WB     = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] sub_r;
  logic [KW-1:0] k_r;
  logic ph_r;
  logic [AW-1:0] idx_r, i_r, clr_r;
  logic [15:0] decay_r;
  logic [31:0] eps_r;

  logic [31:0] gmag_r;
  logic gneg_r;
  logic signed [31:0] param_r;
  logic [KW-1:0] s_r;
  logic last_r, bad_r;
  logic [MEAN_W-1:0] x_r, tmp_r, mg_r, ms_r;
  logic [MEAN_W-1:0] wg_r [NUM_WORKERS];
  logic [MEAN_W-1:0] ws_r [NUM_WORKERS];
  logic [WGT_W-1:0] weight_r [NUM_WORKERS];
  logic [MUL_W-1:0] acc_r;
  logic [31:0] sn_r, sd_r;
  logic [40:0] smag_r;
  logic [31:0] result_r;
  logic out_valid_r;
  out_item_t out_data_r;

  logic [MEAN_W-1:0] mg_mem [PARAM_COUNT];
  logic [MEAN_W-1:0] ms_mem [PARAM_COUNT];
  logic [ROW_W-1:0] wg_mem [PARAM_COUNT];
  logic [ROW_W-1:0] ws_mem [PARAM_COUNT];
  logic [MEAN_W-1:0] mg_rd_r, ms_rd_r;
  logic [ROW_W-1:0] wg_rd_r, ws_rd_r;

  logic in_acc, in_ok;
  logic [KW-1:0] in_s;
  logic [31:0] in_gmag;
  logic [AW-1:0] idx_nxt, mem_addr;
  logic mem_we, clearing;
  logic [MEAN_W-1:0] mg_wd, ms_wd;
  logic [ROW_W-1:0] wg_wd, ws_wd;
  logic [MEAN_W-1:0] mul_a, fold_m, wsel;
  logic [WGT_W-1:0] mul_b;
  logic [MUL_W-1:0] p_r;
  logic [63:0] pp_sum;
  logic [65:0] fsum;
  logic [49:0] wsum;
  logic [MEAN_W-1:0] wsat;
  logic [48:0] rnum;
  logic [63:0] rd_opa;
  rd_req_t rd_req;
  rd_rsp_t rd_rsp;
  logic signed [42:0] p_ext, m_ext, r_ext;
  logic [31:0] r_sat;

  assign clearing = (state_r == S_CLEAR);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign in_ok = (in_data.worker_rank != 3'd0) && (in_data.worker_rank <= RANK_MAX);
  assign in_s = KW'(in_data.worker_rank - 3'd1);
  assign in_gmag = in_data.grad_value[31] ? (~in_data.grad_value + 32'd1)
                                          : in_data.grad_value;
  assign idx_nxt = (in_data.last_element || idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  adsw_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (p_r)
  );

  adsw_rootdiv u_rootdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rd_req),
    .opa   (rd_opa),
    .opb   (sd_r),
    .rsp   (rd_rsp)
  );

  assign fold_m = ph_r ? ms_r : mg_r;
  assign wsel = ph_r ? ws_r[k_r] : wg_r[k_r];
  assign pp_sum = acc_r[63:0] + {p_r[47:0], 16'd0};
  assign fsum = {1'b0, acc_r} + {1'b0, p_r};
  assign wsum = {2'b00, wsel} + {1'b0, p_r[MUL_W-1:16]};
  assign wsat = (wsum[49:48] != 2'b00) ? MEAN_MAX : wsum[47:0];
  assign rnum = {1'b0, (state_r == S_ROOT_N) ? ws_r[k_r] : wg_r[k_r]} + 49'(eps_r);
  assign rd_opa = (state_r == S_DIV) ? acc_r[63:0] : {1'b0, rnum, 14'd0};
  assign rd_req.start = ((state_r == S_ROOT_N) || (state_r == S_ROOT_D) ||
                         (state_r == S_DIV)) && (sub_r == 2'd0);
  assign rd_req.op = (state_r == S_DIV) ? RD_DIV : RD_SQRT;

  assign p_ext = 43'(param_r);
  assign m_ext = signed'({2'b00, smag_r});
  assign r_ext = gneg_r ? (p_ext + m_ext) : (p_ext - m_ext);
  assign r_sat = (r_ext[42:31] == {12{r_ext[42]}}) ? r_ext[31:0]
               : (r_ext[42] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DECAY: begin
        mul_a = MEAN_W'(weight_r[k_r]);
        mul_b = {1'b0, decay_r};
      end
      S_GSQ: begin
        mul_a = MEAN_W'(gmag_r);
        mul_b = {1'b0, (sub_r == 2'd0) ? gmag_r[15:0] : gmag_r[31:16]};
      end
      S_NUM: begin
        mul_a = MEAN_W'(gmag_r);
        mul_b = {1'b0, (sub_r == 2'd0) ? sn_r[15:0] : sn_r[31:16]};
      end
      S_SSQ: begin
        mul_a = MEAN_W'(smag_r[23:0]);
        mul_b = {1'b0, (sub_r == 2'd0) ? smag_r[15:0] : {8'd0, smag_r[23:16]}};
      end
      S_FOLD_G: begin
        if (sub_r == 2'd0) begin
          mul_a = fold_m;
          mul_b = {1'b0, decay_r};
        end else begin
          mul_a = x_r;
          mul_b = WGT_ONE - {1'b0, decay_r};
        end
      end
      S_FOLD_W: begin
        if (!sub_r[1]) begin
          mul_a = x_r;
          mul_b = weight_r[k_r];
        end else begin
          mul_a = tmp_r;
          mul_b = SHRINK_Q16;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (idx_r == '0) ? S_DECAY : (in_ok ? S_RD : S_DONE);
        end
      end
      S_DECAY:  if (sub_r[0] && k_r == LAST_K) state_nxt = bad_r ? S_DONE : S_RD;
      S_RD:     state_nxt = S_LD;
      S_LD:     state_nxt = S_GSQ;
      S_GSQ:    if (sub_r == 2'd2) state_nxt = S_FOLD_G;
      S_FOLD_G: if (sub_r == 2'd2) state_nxt = S_FOLD_W;
      S_FOLD_W: if (sub_r == 2'd3 && k_r == LAST_K) state_nxt = ph_r ? S_WB : S_ROOT_N;
      S_ROOT_N: if (sub_r[0] && rd_rsp.done) state_nxt = S_ROOT_D;
      S_ROOT_D: if (sub_r[0] && rd_rsp.done) state_nxt = S_NUM;
      S_NUM:    if (sub_r == 2'd2) state_nxt = S_DIV;
      S_DIV:    if (sub_r[0] && rd_rsp.done) state_nxt = S_STEP;
      S_STEP:   state_nxt = (smag_r[40:24] != '0) ? S_FOLD_G : S_SSQ;
      S_SSQ:    if (sub_r == 2'd2) state_nxt = S_FOLD_G;
      S_WB:     state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sub_r <= '0;
      k_r <= '0;
      ph_r <= 1'b0;
      idx_r <= '0;
      clr_r <= '0;
      decay_r <= DECAY_RESET;
      eps_r <= EPS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        sub_r <= '0;
      end else if (state_r == S_DECAY) begin
        sub_r <= {1'b0, ~sub_r[0]};
      end else if ((state_r == S_ROOT_N) || (state_r == S_ROOT_D) || (state_r == S_DIV)) begin
        sub_r <= 2'd1;
      end else begin
        sub_r <= sub_r + 2'd1;
      end
      if (state_r == S_IDLE || state_r == S_FOLD_G) begin
        k_r <= '0;
      end else if (state_r == S_DECAY && sub_r[0]) begin
        k_r <= k_r + 1'b1;
      end else if (state_r == S_FOLD_W && sub_r == 2'd3) begin
        k_r <= (k_r == LAST_K) ? s_r : k_r + 1'b1;
      end
      if (state_r == S_IDLE) begin
        ph_r <= 1'b0;
      end else if (state_r == S_STEP) begin
        ph_r <= 1'b1;
      end
      if (in_acc) begin
        idx_r <= idx_nxt;
      end
      if (clearing) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DECAY: decay_r <= cfg_data[15:0];
          REG_EPS:   eps_r <= cfg_data;
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_WORKERS; k++) begin
        weight_r[k] <= WGT_RESET;
      end
    end else if (state_r == S_DECAY && sub_r[0]) begin
      weight_r[k_r] <= p_r[32:16];
    end else if (state_r == S_WB && last_r) begin
      weight_r[s_r] <= WGT_ONE - {1'b0, decay_r};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gmag_r <= in_gmag;
      gneg_r <= in_data.grad_value[31];
      param_r <= in_data.param_in;
      result_r <= in_data.param_in;
      s_r <= in_s;
      last_r <= in_data.last_element;
      bad_r <= !in_ok;
      i_r <= idx_r;
    end
    if (state_r == S_LD) begin
      mg_r <= mg_rd_r;
      ms_r <= ms_rd_r;
      for (int k = 0; k < NUM_WORKERS; k++) begin
        wg_r[k] <= wg_rd_r[k*MEAN_W +: MEAN_W];
        ws_r[k] <= ws_rd_r[k*MEAN_W +: MEAN_W];
      end
    end
    if ((state_r == S_GSQ || state_r == S_FOLD_G || state_r == S_NUM ||
         state_r == S_SSQ) && sub_r == 2'd1) begin
      acc_r <= p_r;
    end
    if (state_r == S_GSQ && sub_r == 2'd2) begin
      x_r <= (pp_sum[63:48] != '0) ? MEAN_MAX : pp_sum[47:0];
    end
    if (state_r == S_FOLD_G && sub_r == 2'd2) begin
      if (ph_r) begin
        ms_r <= fsum[63:16];
      end else begin
        mg_r <= fsum[63:16];
      end
    end
    if (state_r == S_FOLD_W && sub_r == 2'd1) begin
      tmp_r <= wsat;
    end
    if (state_r == S_FOLD_W && sub_r == 2'd3) begin
      if (ph_r) begin
        ws_r[k_r] <= p_r[63:16];
      end else begin
        wg_r[k_r] <= p_r[63:16];
      end
    end
    if (state_r == S_ROOT_N && sub_r[0] && rd_rsp.done) begin
      sn_r <= rd_rsp.result[31:0];
    end
    if (state_r == S_ROOT_D && sub_r[0] && rd_rsp.done) begin
      sd_r <= (rd_rsp.result[31:0] == '0) ? 32'd1 : rd_rsp.result[31:0];
    end
    if (state_r == S_NUM && sub_r == 2'd2) begin
      acc_r <= {1'b0, pp_sum};
    end
    if (state_r == S_DIV && sub_r[0] && rd_rsp.done) begin
      smag_r <= (rd_rsp.result > 64'(STEP_MAX)) ? STEP_MAX : rd_rsp.result[40:0];
    end
    if (state_r == S_STEP) begin
      result_r <= r_sat;
      x_r <= MEAN_MAX;
    end
    if (state_r == S_SSQ && sub_r == 2'd2) begin
      x_r <= pp_sum[47:0];
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.param_out <= result_r;
      out_data_r.bad_rank <= bad_r;
      out_data_r.last_out <= last_r;
    end
  end

  assign mem_addr = clearing ? clr_r : i_r;
  assign mem_we = clearing || (state_r == S_WB);
  assign mg_wd = clearing ? '0 : mg_r;
  assign ms_wd = clearing ? '0 : ms_r;

  always_comb begin
    for (int k = 0; k < NUM_WORKERS; k++) begin
      wg_wd[k*MEAN_W +: MEAN_W] = (KW'(k) == s_r) ? mg_r : wg_r[k];
      ws_wd[k*MEAN_W +: MEAN_W] = (KW'(k) == s_r) ? ms_r : ws_r[k];
    end
    if (clearing) begin
      wg_wd = '0;
      ws_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mg_mem[mem_addr] <= mg_wd;
      ms_mem[mem_addr] <= ms_wd;
      wg_mem[mem_addr] <= wg_wd;
      ws_mem[mem_addr] <= ws_wd;
    end
    mg_rd_r <= mg_mem[mem_addr];
    ms_rd_r <= ms_mem[mem_addr];
    wg_rd_r <= wg_mem[mem_addr];
    ws_rd_r <= ws_mem[mem_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
endmodule
`default_nettype wire

[design/adsw_checker.sv]
// Port-level checks for the stale-worker Adadelta update block, bound to its top level.
// Depends on adsw_pkg.
`default_nettype none
module adsw_checker import adsw_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input in_item_t             in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_item_t            out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]          cfg_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during reset or clearing");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without transaction in flight");
endmodule

bind adadelta_stale_worker_update_top adsw_checker u_adsw_checker (.*);
`default_nettype wire
